// ----- design/text_console_scrollback_defines.svh -----
// ----------------------------------------------------------------------------
// Text console scrollback: assertion macros
// Shared property forms used by the console top level. Each expects signals
// named clock and reset in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_SCROLLBACK_DEFINES_SVH
`define TEXT_CONSOLE_SCROLLBACK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCS_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCS_ASSERT_NXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- design/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console scrollback: shared package
// Operation and character codes, command kinds and the command record that
// the front end hands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

   localparam int OP_W    = 3;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int CELL_W  = 16;
   localparam int LOC_W   = 11;
   localparam int VLINE_W = 7;
   localparam int KIND_W  = 4;

   localparam logic [OP_W-1:0] OP_PUT_CHAR    = 3'd0;
   localparam logic [OP_W-1:0] OP_SCROLL_UP   = 3'd1;
   localparam logic [OP_W-1:0] OP_SCROLL_DOWN = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR       = 3'd3;
   localparam logic [OP_W-1:0] OP_READ        = 3'd4;

   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;

   localparam logic [KIND_W-1:0] CMD_NOP         = 4'd0;
   localparam logic [KIND_W-1:0] CMD_CHAR        = 4'd1;
   localparam logic [KIND_W-1:0] CMD_NEWLINE     = 4'd2;
   localparam logic [KIND_W-1:0] CMD_BACKSPACE   = 4'd3;
   localparam logic [KIND_W-1:0] CMD_TAB         = 4'd4;
   localparam logic [KIND_W-1:0] CMD_SCROLL_UP   = 4'd5;
   localparam logic [KIND_W-1:0] CMD_SCROLL_DOWN = 4'd6;
   localparam logic [KIND_W-1:0] CMD_CLEAR       = 4'd7;
   localparam logic [KIND_W-1:0] CMD_READ        = 4'd8;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAR_W-1:0]  char_code;
      logic               snap;
      logic [INDEX_W-1:0] cell_index;
      logic               in_range;
   } cmd_type;

endpackage

`default_nettype wire

// ----- design/tcs_front.sv -----
// ----------------------------------------------------------------------------
// Text console scrollback: front end
// Accepts request transactions, classifies them into commands and hands
// them to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_front import tcs_pkg::*; #(
   parameter int unsigned SCREEN_CELLS = 2000
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [CHAR_W-1:0]  req_char_code,
   input  wire logic               req_string_end,
   input  wire logic [INDEX_W-1:0] req_cell_index,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output cmd_type                 push_cmd
);

   logic    valid_ff;
   logic    valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    accept;

   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      cmd_in            = cmd_ff;
      cmd_in.char_code  = req_char_code;
      cmd_in.cell_index = req_cell_index;
      cmd_in.snap       = 1'b0;
      cmd_in.in_range   = ({21'b0, req_cell_index} < SCREEN_CELLS);
      unique case (req_operation)
         OP_PUT_CHAR: begin
            cmd_in.snap = req_string_end;
            unique case (req_char_code)
               CH_NEWLINE:   cmd_in.kind = CMD_NEWLINE;
               CH_BACKSPACE: cmd_in.kind = CMD_BACKSPACE;
               CH_TAB:       cmd_in.kind = CMD_TAB;
               default:      cmd_in.kind = CMD_CHAR;
            endcase
         end
         OP_SCROLL_UP:   cmd_in.kind = CMD_SCROLL_UP;
         OP_SCROLL_DOWN: cmd_in.kind = CMD_SCROLL_DOWN;
         OP_CLEAR:       cmd_in.kind = CMD_CLEAR;
         OP_READ:        cmd_in.kind = CMD_READ;
         default:        cmd_in.kind = CMD_NOP;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/tcs_queue.sv -----
// ----------------------------------------------------------------------------
// Text console scrollback: command queue
// Short first-in first-out queue of commands between the front end and the
// back end, so that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_queue import tcs_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  wire cmd_type push_cmd,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output cmd_type   pop_cmd
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- design/tcs_back.sv -----
// ----------------------------------------------------------------------------
// Text console scrollback: back end
// Owns the scrollback ring memory, the cursor and view positions and the
// color register. Carries out one command at a time and loads the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_back import tcs_pkg::*; #(
   parameter int unsigned COLUMNS   = 80,
   parameter int unsigned ROWS      = 25,
   parameter int unsigned SCREENS   = 5,
   parameter int unsigned TAB_WIDTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CHAR_W-1:0]  csr_text_color,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   input  wire cmd_type            cmd,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [CELL_W-1:0]       rsp_cell_value,
   output logic [LOC_W-1:0]        rsp_cursor_location,
   output logic [VLINE_W-1:0]      rsp_view_line
);

   localparam int SCREEN_CELLS = COLUMNS * ROWS;
   localparam int RING_CELLS   = SCREEN_CELLS * SCREENS;
   localparam int LINES        = ROWS * SCREENS;
   localparam int POS_W        = $clog2(RING_CELLS);
   localparam int P1           = POS_W + 1;
   localparam int LINE_W       = $clog2(LINES);
   localparam int L1           = LINE_W + 1;
   localparam int COL_W        = $clog2(COLUMNS);
   localparam int TMOD_W       = $clog2(TAB_WIDTH);
   localparam int T1           = TMOD_W + 1;
   localparam int SUM_W        = ((POS_W > INDEX_W) ? POS_W : INDEX_W) + 1;
   localparam int LOCX_W       = (P1 > LOC_W) ? P1 : LOC_W;
   localparam int VLX_W        = (LINE_W > VLINE_W) ? LINE_W : VLINE_W;
   localparam int SNAP_BACK    = COLUMNS * (ROWS - 1);
   localparam int CSTEP        = COLUMNS % TAB_WIDTH;

   localparam logic [POS_W-1:0]  RING_LAST  = POS_W'(RING_CELLS - 1);
   localparam logic [POS_W-1:0]  RESET_POS  = POS_W'(SCREEN_CELLS);
   localparam logic [LINE_W-1:0] LINE_LAST  = LINE_W'(LINES - 1);
   localparam logic [LINE_W-1:0] RESET_LINE = LINE_W'(ROWS);
   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [TMOD_W-1:0] TAB_LAST   = TMOD_W'(TAB_WIDTH - 1);
   localparam logic [TMOD_W-1:0] RESET_TMOD = TMOD_W'(SCREEN_CELLS % TAB_WIDTH);
   localparam logic [TMOD_W-1:0] LAST_TMOD  = TMOD_W'((RING_CELLS - 1) % TAB_WIDTH);
   localparam logic [TMOD_W-1:0] LAST_LMOD  = TMOD_W'(((LINES - 1) * COLUMNS) % TAB_WIDTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FILL = 3'd1;
   localparam logic [2:0] ST_TAB  = 3'd2;
   localparam logic [2:0] ST_SNAP = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [CELL_W-1:0] ring_mem [RING_CELLS];

   logic [2:0]         state_ff,     state_in;
   logic [POS_W-1:0]   pos_ff,       pos_in;
   logic [COL_W-1:0]   col_ff,       col_in;
   logic [LINE_W-1:0]  line_ff,      line_in;
   logic [TMOD_W-1:0]  tmod_ff,      tmod_in;
   logic [TMOD_W-1:0]  lmod_ff,      lmod_in;
   logic [POS_W-1:0]   view_pos_ff,  view_pos_in;
   logic [LINE_W-1:0]  view_line_ff, view_line_in;
   logic [CHAR_W-1:0]  color_ff;
   logic [POS_W-1:0]   fill_addr_ff, fill_addr_in;
   logic [CELL_W-1:0]  fill_data_ff, fill_data_in;
   logic [POS_W-1:0]   count_ff,     count_in;
   logic               silent_ff,    silent_in;
   logic               snap_ff,      snap_in;
   logic               cell_sel_ff,  cell_sel_in;
   logic [CELL_W-1:0]  rd_data_ff;
   logic               rsp_valid_ff;
   logic [CELL_W-1:0]  rsp_cell_ff;
   logic [LOC_W-1:0]   rsp_loc_ff;
   logic [VLINE_W-1:0] rsp_line_ff;

   logic [CELL_W-1:0]  blank;
   logic               mem_we;
   logic [POS_W-1:0]   mem_waddr;
   logic [CELL_W-1:0]  mem_wdata;
   logic [POS_W-1:0]   mem_raddr;
   logic               rd_en;
   logic               rsp_fire;
   logic [2:0]         after_put;

   logic [LINE_W-1:0]  nxt_line, prv_line;
   logic [TMOD_W-1:0]  nxt_lmod, prv_lmod;
   logic [T1-1:0]      lsum, psum;
   logic [POS_W-1:0]   adv_pos, bs_pos, nl_pos;
   logic [COL_W-1:0]   adv_col, bs_col;
   logic [LINE_W-1:0]  adv_line, bs_line;
   logic [TMOD_W-1:0]  adv_tmod, bs_tmod, adv_lmod, bs_lmod;
   logic [P1-1:0]      nl_sum;
   logic [POS_W-1:0]   lstart;
   logic [P1-1:0]      snap_sum, up_sum, dn_sum;
   logic [POS_W-1:0]   snap_pos, up_pos, dn_pos;
   logic [L1-1:0]      snap_lsum;
   logic [LINE_W-1:0]  snap_line, up_line, dn_line;
   logic [SUM_W-1:0]   rd_sum;
   logic [P1-1:0]      cursor_offset;
   logic [P1-1:0]      loc;
   logic [LOCX_W-1:0]  loc_wide;
   logic [VLX_W-1:0]   vline_wide;
   logic [POS_W-1:0]   fill_next;

   assign blank     = {color_ff, CH_SPACE};
   assign csr_ready = 1'b1;
   assign cmd_ready = (state_ff == ST_IDLE);

   // Line stepping, with the line start position modulo the tab width.
   assign lsum     = T1'(lmod_ff) + T1'(CSTEP);
   assign psum     = T1'(lmod_ff) + T1'(TAB_WIDTH - CSTEP);
   assign nxt_line = (line_ff == LINE_LAST) ? '0 : line_ff + 1'b1;
   assign prv_line = (line_ff == '0) ? LINE_LAST : line_ff - 1'b1;
   assign nxt_lmod = (line_ff == LINE_LAST) ? '0 :
                     (lsum >= T1'(TAB_WIDTH)) ? TMOD_W'(lsum - T1'(TAB_WIDTH)) :
                     TMOD_W'(lsum);
   assign prv_lmod = (line_ff == '0) ? LAST_LMOD :
                     (psum >= T1'(TAB_WIDTH)) ? TMOD_W'(psum - T1'(TAB_WIDTH)) :
                     TMOD_W'(psum);

   // Cursor forward one cell.
   assign adv_pos  = (pos_ff == RING_LAST) ? '0 : pos_ff + 1'b1;
   assign adv_tmod = (pos_ff == RING_LAST || tmod_ff == TAB_LAST) ? '0 : tmod_ff + 1'b1;
   assign adv_col  = (col_ff == COL_LAST) ? '0 : col_ff + 1'b1;
   assign adv_line = (col_ff == COL_LAST) ? nxt_line : line_ff;
   assign adv_lmod = (col_ff == COL_LAST) ? nxt_lmod : lmod_ff;

   // Cursor back one cell.
   assign bs_pos  = (pos_ff == '0) ? RING_LAST : pos_ff - 1'b1;
   assign bs_tmod = (pos_ff == '0) ? LAST_TMOD :
                    (tmod_ff == '0) ? TAB_LAST : tmod_ff - 1'b1;
   assign bs_col  = (col_ff == '0) ? COL_LAST : col_ff - 1'b1;
   assign bs_line = (col_ff == '0) ? prv_line : line_ff;
   assign bs_lmod = (col_ff == '0) ? prv_lmod : lmod_ff;

   // Start of the next line.
   assign nl_sum = P1'(pos_ff) - P1'(col_ff) + P1'(COLUMNS);
   assign nl_pos = (nl_sum >= P1'(RING_CELLS)) ? POS_W'(nl_sum - P1'(RING_CELLS)) :
                   POS_W'(nl_sum);

   // View placed so that the cursor line is the bottom screen line.
   assign lstart    = pos_ff - POS_W'(col_ff);
   assign snap_sum  = P1'(lstart) + P1'(RING_CELLS - SNAP_BACK);
   assign snap_pos  = (snap_sum >= P1'(RING_CELLS)) ?
                      POS_W'(snap_sum - P1'(RING_CELLS)) : POS_W'(snap_sum);
   assign snap_lsum = L1'(line_ff) + L1'(LINES - (ROWS - 1));
   assign snap_line = (snap_lsum >= L1'(LINES)) ? LINE_W'(snap_lsum - L1'(LINES)) :
                      LINE_W'(snap_lsum);

   // Scrolling by one line.
   assign up_sum  = P1'(view_pos_ff) + P1'(RING_CELLS - COLUMNS);
   assign up_pos  = (up_sum >= P1'(RING_CELLS)) ? POS_W'(up_sum - P1'(RING_CELLS)) :
                    POS_W'(up_sum);
   assign dn_sum  = P1'(view_pos_ff) + P1'(COLUMNS);
   assign dn_pos  = (dn_sum >= P1'(RING_CELLS)) ? POS_W'(dn_sum - P1'(RING_CELLS)) :
                    POS_W'(dn_sum);
   assign up_line = (view_line_ff == '0) ? LINE_LAST : view_line_ff - 1'b1;
   assign dn_line = (view_line_ff == LINE_LAST) ? '0 : view_line_ff + 1'b1;

   // Visible cell address.
   assign rd_sum    = SUM_W'(view_pos_ff) + SUM_W'(cmd.cell_index);
   assign mem_raddr = (rd_sum >= SUM_W'(RING_CELLS)) ?
                      POS_W'(rd_sum - SUM_W'(RING_CELLS)) : POS_W'(rd_sum);

   // Cursor offset on the screen.
   assign cursor_offset = (view_pos_ff > pos_ff) ?
                          P1'(pos_ff) + P1'(RING_CELLS) - P1'(view_pos_ff) :
                          P1'(pos_ff) - P1'(view_pos_ff);
   assign loc        = (cursor_offset < P1'(SCREEN_CELLS)) ? cursor_offset :
                       P1'(SCREEN_CELLS);
   assign loc_wide   = LOCX_W'(loc);
   assign vline_wide = VLX_W'(view_line_ff);

   assign fill_next = (fill_addr_ff == RING_LAST) ? '0 : fill_addr_ff + 1'b1;
   assign after_put = snap_ff ? ST_SNAP : ST_DONE;
   assign rsp_fire  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      tmod_in      = tmod_ff;
      lmod_in      = lmod_ff;
      view_pos_in  = view_pos_ff;
      view_line_in = view_line_ff;
      fill_addr_in = fill_addr_ff;
      fill_data_in = fill_data_ff;
      count_in     = count_ff;
      silent_in    = silent_ff;
      snap_in      = snap_ff;
      cell_sel_in  = cell_sel_ff;
      mem_we       = 1'b0;
      mem_waddr    = fill_addr_ff;
      mem_wdata    = fill_data_ff;
      rd_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               snap_in     = cmd.snap;
               cell_sel_in = (cmd.kind == CMD_READ) && cmd.in_range;
               state_in    = ST_DONE;
               unique case (cmd.kind)
                  CMD_CHAR: begin
                     mem_we    = 1'b1;
                     mem_waddr = pos_ff;
                     mem_wdata = {color_ff, cmd.char_code};
                     pos_in    = adv_pos;
                     col_in    = adv_col;
                     line_in   = adv_line;
                     tmod_in   = adv_tmod;
                     lmod_in   = adv_lmod;
                     state_in  = cmd.snap ? ST_SNAP : ST_DONE;
                  end
                  CMD_BACKSPACE: begin
                     mem_we    = 1'b1;
                     mem_waddr = bs_pos;
                     mem_wdata = blank;
                     pos_in    = bs_pos;
                     col_in    = bs_col;
                     line_in   = bs_line;
                     tmod_in   = bs_tmod;
                     lmod_in   = bs_lmod;
                     state_in  = cmd.snap ? ST_SNAP : ST_DONE;
                  end
                  CMD_NEWLINE: begin
                     pos_in       = nl_pos;
                     col_in       = '0;
                     line_in      = nxt_line;
                     tmod_in      = nxt_lmod;
                     lmod_in      = nxt_lmod;
                     fill_addr_in = nl_pos;
                     fill_data_in = blank;
                     count_in     = POS_W'(COLUMNS - 1);
                     silent_in    = 1'b0;
                     state_in     = ST_FILL;
                  end
                  CMD_TAB: begin
                     count_in = POS_W'(TAB_WIDTH - 1) - POS_W'(tmod_ff);
                     state_in = ST_TAB;
                  end
                  CMD_SCROLL_UP: begin
                     view_pos_in  = up_pos;
                     view_line_in = up_line;
                  end
                  CMD_SCROLL_DOWN: begin
                     view_pos_in  = dn_pos;
                     view_line_in = dn_line;
                  end
                  CMD_CLEAR: begin
                     pos_in       = RESET_POS;
                     col_in       = '0;
                     line_in      = RESET_LINE;
                     tmod_in      = RESET_TMOD;
                     lmod_in      = RESET_TMOD;
                     view_pos_in  = '0;
                     view_line_in = '0;
                     fill_addr_in = '0;
                     fill_data_in = blank;
                     count_in     = RING_LAST;
                     silent_in    = 1'b0;
                     state_in     = ST_FILL;
                  end
                  CMD_READ: begin
                     rd_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            mem_we       = 1'b1;
            fill_addr_in = fill_next;
            count_in     = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = silent_ff ? ST_IDLE : after_put;
            end
         end
         ST_TAB: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = blank;
            pos_in    = adv_pos;
            col_in    = adv_col;
            line_in   = adv_line;
            tmod_in   = adv_tmod;
            lmod_in   = adv_lmod;
            count_in  = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = after_put;
            end
         end
         ST_SNAP: begin
            view_pos_in  = snap_pos;
            view_line_in = snap_line;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         pos_ff       <= RESET_POS;
         col_ff       <= '0;
         line_ff      <= RESET_LINE;
         tmod_ff      <= RESET_TMOD;
         lmod_ff      <= RESET_TMOD;
         view_pos_ff  <= '0;
         view_line_ff <= '0;
         color_ff     <= RESET_COLOR;
         fill_addr_ff <= '0;
         fill_data_ff <= {RESET_COLOR, CH_SPACE};
         count_ff     <= RING_LAST;
         silent_ff    <= 1'b1;
         snap_ff      <= 1'b0;
         cell_sel_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         tmod_ff      <= tmod_in;
         lmod_ff      <= lmod_in;
         view_pos_ff  <= view_pos_in;
         view_line_ff <= view_line_in;
         fill_addr_ff <= fill_addr_in;
         fill_data_ff <= fill_data_in;
         count_ff     <= count_in;
         silent_ff    <= silent_in;
         snap_ff      <= snap_in;
         cell_sel_ff  <= cell_sel_in;
         if (csr_valid) begin
            color_ff <= csr_text_color;
         end
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_fire) begin
         rsp_cell_ff <= cell_sel_ff ? rd_data_ff : '0;
         rsp_loc_ff  <= loc_wide[LOC_W-1:0];
         rsp_line_ff <= vline_wide[VLINE_W-1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_value      = rsp_cell_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_view_line       = rsp_line_ff;

endmodule

`default_nettype wire

// ----- design/text_console_scrollback.sv -----
// ----------------------------------------------------------------------------
// Text console scrollback: top level
// Character console engine with a ring scrollback of COLUMNS*ROWS*SCREENS
// cells. A front end classifies requests into a two-entry command queue and
// a back end executes them against the ring memory, one write per cycle.
// From command pop to result: plain characters, backspace, scrolls, reads
// and unknown operations go straight to the result; a tab first blanks the
// cells up to the next tab stop (1 to TAB_WIDTH); a newline blanks the
// COLUMNS cells of the new line; a clear blanks the whole ring; string end
// also places the cursor line at the bottom of the view. The blanking
// walks go through the single write port of the ring memory.
// After reset the ring is blanked while requests still enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_scrollback_defines.svh"

module text_console_scrollback import tcs_pkg::*; #(
   parameter int unsigned COLUMNS   = 80,
   parameter int unsigned ROWS      = 25,
   parameter int unsigned SCREENS   = 5,
   parameter int unsigned TAB_WIDTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [CHAR_W-1:0]  req_char_code,
   input  wire logic               req_string_end,
   input  wire logic [INDEX_W-1:0] req_cell_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [CELL_W-1:0]       rsp_cell_value,
   output logic [LOC_W-1:0]        rsp_cursor_location,
   output logic [VLINE_W-1:0]      rsp_view_line,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CHAR_W-1:0]  csr_text_color
);

   logic    cmd_push_valid;
   logic    cmd_push_ready;
   cmd_type cmd_push;
   logic    cmd_pop_valid;
   logic    cmd_pop_ready;
   cmd_type cmd_pop;

   tcs_front #(
      .SCREEN_CELLS (COLUMNS * ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .req_string_end (req_string_end),
      .req_cell_index (req_cell_index),
      .push_valid     (cmd_push_valid),
      .push_ready     (cmd_push_ready),
      .push_cmd       (cmd_push)
   );

   tcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_push_valid),
      .push_ready (cmd_push_ready),
      .push_cmd   (cmd_push),
      .pop_valid  (cmd_pop_valid),
      .pop_ready  (cmd_pop_ready),
      .pop_cmd    (cmd_pop)
   );

   tcs_back #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .SCREENS   (SCREENS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_text_color      (csr_text_color),
      .cmd_valid           (cmd_pop_valid),
      .cmd_ready           (cmd_pop_ready),
      .cmd                 (cmd_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_location (rsp_cursor_location),
      .rsp_view_line       (rsp_view_line)
   );

   `TCS_ASSERT_IMP(a_stall_only_when_queue_full, req_stall, cmd_push_valid && !cmd_push_ready, "Request stalled while the command queue could take the held command.")
   `TCS_ASSERT_NXT(a_back_busy_after_pop, cmd_pop_valid && cmd_pop_ready, !cmd_pop_ready, "Back end popped a command without leaving its idle state.")
   `TCS_ASSERT_IMP(a_result_from_busy_back, $rose(rsp_valid), $past(!cmd_pop_ready), "Result appeared while the back end had been idle.")

endmodule

`default_nettype wire
